// File: rtl/core/sha256_pkg.sv
package sha256_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic absorb;
		logic pad_mark;
		logic pad_zero;
		logic pad_len;
		logic load_wv;
		logic round;
		logic fold;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rem_done;
		logic rem_zero;
		logic item_last;
		logic wrap;
		logic blk_end;
		logic at_len;
		logic round_last;
		logic out_busy;
	} sts_t;

	function automatic logic [31:0] big0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: rtl/core/sha256_dp.sv
module sha256_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::in_item_t  in_item,
	input  sha256_pkg::cmd_t      cmd,
	output sha256_pkg::sts_t      sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_item
);
	import sha256_pkg::*;

	logic [31:0] cv_q [8];
	logic [31:0] wv_q [8];
	logic [31:0] blk_q [16];
	logic [31:0] out_q [8];
	logic [31:0] hold_q;
	logic [2:0]  rem_q;
	logic        last_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [63:0] bits_q;
	logic [3:0]  out_left_q;
	logic [2:0]  out_idx_q;

	logic [3:0]  wsel;
	logic [1:0]  boff;
	logic [2:0]  room;
	logic [2:0]  take;
	logic [6:0]  fill_sum;
	logic [31:0] hold_sh;
	logic [31:0] merged;
	logic [31:0] marked;
	logic [31:0] cur_word;
	logic [2:0]  rem_after;
	logic [2:0]  cnt_sat;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] sched_new;
	logic        out_take;

	assign wsel      = fill_q[5:2];
	assign boff      = fill_q[1:0];
	assign room      = 3'd4 - {1'b0, boff};
	assign take      = (rem_q < room) ? rem_q : room;
	assign fill_sum  = {1'b0, fill_q} + {4'b0000, take};
	assign rem_after = rem_q - take;
	assign hold_sh   = hold_q >> {boff, 3'b000};
	assign cur_word  = blk_q[wsel];
	assign cnt_sat   = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
	assign out_take  = out_valid && out_ready;

	// merge the next bytes of the held item into the current block word
	always_comb begin
		logic [2:0] lane;
		logic [2:0] rel;
		merged = cur_word;
		marked = cur_word;
		for (int j = 0; j < 4; j++) begin
			lane = 3'(j);
			rel  = lane - {1'b0, boff};
			if (lane >= {1'b0, boff} && rel < take)
				merged[31 - 8*j -: 8] = hold_sh[31 - 8*j -: 8];
			if (lane == {1'b0, boff})
				marked[31 - 8*j -: 8] = PAD_MARK;
			else if (lane > {1'b0, boff})
				marked[31 - 8*j -: 8] = 8'h00;
		end
	end

	assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1  = wv_q[7] + big1(wv_q[4]) + ch + ROUND_K[rnd_q] + blk_q[0];
	assign t2  = big0(wv_q[0]) + maj;
	assign sched_new = sig1(blk_q[14]) + blk_q[9] + sig0(blk_q[1]) + blk_q[0];

	always_comb begin
		sts            = '0;
		sts.rem_done   = (rem_after == 3'd0);
		sts.rem_zero   = (rem_q == 3'd0);
		sts.item_last  = last_q;
		sts.wrap       = fill_sum[6];
		sts.blk_end    = (wsel == 4'd15);
		sts.at_len     = (wsel == 4'd14);
		sts.round_last = (rnd_q == 6'd63);
		sts.out_busy   = (out_left_q != 4'd0);
	end

	// chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= HASH_INIT[i];
		end else if (cmd.emit) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= HASH_INIT[i];
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++)
				cv_q[i] <= cv_q[i] + wv_q[i];
		end
	end

	// block buffer, shifted as the message schedule window during rounds
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			blk_q[wsel] <= merged;
		end else if (cmd.pad_mark) begin
			blk_q[wsel] <= marked;
		end else if (cmd.pad_zero) begin
			blk_q[wsel] <= '0;
		end else if (cmd.pad_len) begin
			blk_q[14] <= bits_q[63:32];
			blk_q[15] <= bits_q[31:0];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++)
				blk_q[i] <= blk_q[i + 1];
			blk_q[15] <= sched_new;
		end
	end

	// working variables a..h
	always_ff @(posedge clk) begin
		if (cmd.load_wv) begin
			for (int i = 0; i < 8; i++)
				wv_q[i] <= cv_q[i];
		end else if (cmd.round) begin
			for (int i = 1; i < 8; i++)
				wv_q[i] <= wv_q[i - 1];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item)
			hold_q <= in_item.data_word;
		else if (cmd.absorb)
			hold_q <= hold_q << {take, 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			last_q <= 1'b0;
			fill_q <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
		end else begin
			if (cmd.load_item) begin
				rem_q  <= cnt_sat;
				last_q <= in_item.last;
			end else if (cmd.absorb) begin
				rem_q <= rem_after;
			end

			if (cmd.emit) begin
				fill_q <= '0;
				bits_q <= '0;
			end else if (cmd.absorb) begin
				fill_q <= fill_sum[5:0];
				bits_q <= bits_q + {58'b0, take, 3'b000};
			end else if (cmd.pad_mark) begin
				fill_q <= {wsel + 4'd1, 2'b00};
			end else if (cmd.pad_zero) begin
				fill_q <= fill_q + 6'd4;
			end else if (cmd.pad_len) begin
				fill_q <= '0;
			end

			if (cmd.load_wv)
				rnd_q <= '0;
			else if (cmd.round)
				rnd_q <= rnd_q + 6'd1;
		end
	end

	// digest output buffer, drains independently of the core
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < 8; i++)
				out_q[i] <= cv_q[i] + wv_q[i];
		end else if (out_take) begin
			for (int i = 0; i < 7; i++)
				out_q[i] <= out_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_left_q <= '0;
			out_idx_q  <= '0;
		end else if (cmd.emit) begin
			out_left_q <= 4'd8;
			out_idx_q  <= '0;
		end else if (out_take) begin
			out_left_q <= out_left_q - 4'd1;
			out_idx_q  <= out_idx_q + 3'd1;
		end
	end

	assign out_valid            = (out_left_q != 4'd0);
	assign out_item.digest_word = out_q[0];
	assign out_item.word_index  = out_idx_q;
	assign out_item.last_word   = (out_idx_q == 3'd7);

	a_emit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_left_q == 4'd0)
		else $error("digest loaded over undrained output");

	a_mark_aligns: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pad_mark |=> fill_q[1:0] == 2'b00)
		else $error("fill position not word aligned after pad mark");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.last_word) |=> !out_valid)
		else $error("output still valid after final digest word");

endmodule

// File: rtl/core/sha256_ctrl.sv
module sha256_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sha256_pkg::sts_t sts,
	output sha256_pkg::cmd_t cmd
);
	import sha256_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_ABSORB   = 7'b0000010,
		S_ROUND    = 7'b0000100,
		S_FINAL    = 7'b0001000,
		S_PAD_MARK = 7'b0010000,
		S_PAD_ZERO = 7'b0100000,
		S_PAD_LEN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_ABSORB;
				end
			end
			S_ABSORB: begin
				cmd.absorb = 1'b1;
				if (sts.wrap) begin
					cmd.load_wv = 1'b1;
					ret_d       = S_ABSORB;
					state_d     = S_ROUND;
				end else if (sts.rem_done) begin
					if (sts.item_last) begin
						state_d = S_PAD_MARK;
					end else begin
						// item finished in this cycle: take the next one straight away
						in_ready = 1'b1;
						if (in_valid)
							cmd.load_item = 1'b1;
						else
							state_d = S_IDLE;
					end
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_last)
					state_d = S_FINAL;
			end
			S_FINAL: begin
				if (ret_q == S_PAD_LEN) begin
					if (!sts.out_busy) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.fold = 1'b1;
					if (ret_q == S_PAD_ZERO)
						state_d = S_PAD_ZERO;
					else if (!sts.rem_zero)
						state_d = S_ABSORB;
					else if (sts.item_last)
						state_d = S_PAD_MARK;
					else
						state_d = S_IDLE;
				end
			end
			S_PAD_MARK: begin
				cmd.pad_mark = 1'b1;
				if (sts.blk_end) begin
					cmd.load_wv = 1'b1;
					ret_d       = S_PAD_ZERO;
					state_d     = S_ROUND;
				end else begin
					state_d = S_PAD_ZERO;
				end
			end
			S_PAD_ZERO: begin
				if (sts.at_len) begin
					state_d = S_PAD_LEN;
				end else begin
					cmd.pad_zero = 1'b1;
					if (sts.blk_end) begin
						cmd.load_wv = 1'b1;
						ret_d       = S_PAD_ZERO;
						state_d     = S_ROUND;
					end
				end
			end
			S_PAD_LEN: begin
				cmd.pad_len = 1'b1;
				cmd.load_wv = 1'b1;
				ret_d       = S_PAD_LEN;
				state_d     = S_ROUND;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_ABSORB;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (state_q == S_IDLE || state_q == S_ABSORB))
		else $error("item accepted while compressing or padding");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && sts.round_last) |=> state_q == S_FINAL)
		else $error("round sequence did not end in final add");

	a_wv_load_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_wv |=> state_q == S_ROUND)
		else $error("working variables loaded without starting rounds");

endmodule

// File: rtl/core/sha256_hash_unit.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_item  (data_word, byte_count, last)
// out      output     out_valid / out_ready  out_item (digest_word, word_index, last_word)
//
// An item that fills no block is only absorbed; one that completes a 64-byte
// block also waits while the single round unit compresses it.
// A last item adds padding and one or two compressions.
// Reset leaves the initial hash loaded, the bit count and fill position at zero.
// The eight digest words drain from their own buffer; a new message may be taken
// meanwhile, and only its final add waits until the buffer is empty.
module sha256_hash_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha256_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_item
);
	import sha256_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: absorb, pad, run rounds, fold or emit
	sha256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: block buffer, schedule window, round unit, digest buffer
	sha256_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: dv/sha256_hash_unit_tb.sv
module sha256_hash_unit_tb;

	import sha256_pkg::*;

	// Digest of the empty message and of "abc", as published for SHA-256
	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam logic [5:0] LEN_AT      = 6'd56;
	localparam int         RAND_ITEMS  = 480;
	localparam int         DRAIN_WAIT  = 200;

	// One row of the directed part: an item and, where it is obvious, its digest
	typedef struct packed {
		in_item_t    item;
		bit          known;
		logic [255:0] want;
	} dir_row_t;

	localparam int DIR_ROWS = 19;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// empty message
		'{'{32'h00000000, 3'd0, 1'b1}, 1'b1, EMPTY_DIGEST},
		// "abc" in one short last word
		'{'{32'h61626300, 3'd3, 1'b1}, 1'b1, ABC_DIGEST},
		// all ones, full word, last
		'{'{32'hffffffff, 3'd4, 1'b1}, 1'b0, 256'h0},
		// byte counts above four are taken as four
		'{'{32'h00000000, 3'd7, 1'b0}, 1'b0, 256'h0},
		'{'{32'hffffffff, 3'd5, 1'b0}, 1'b0, 256'h0},
		'{'{32'h80000000, 3'd6, 1'b0}, 1'b0, 256'h0},
		'{'{32'h00000001, 3'd4, 1'b1}, 1'b0, 256'h0},
		// zero-byte items mid-message, short words that are not last, then short last words
		'{'{32'hdeadbeef, 3'd0, 1'b0}, 1'b0, 256'h0},
		'{'{32'ha5a5a5a5, 3'd2, 1'b0}, 1'b0, 256'h0},
		'{'{32'h5a5a5a5a, 3'd1, 1'b0}, 1'b0, 256'h0},
		'{'{32'hc3c3c3c3, 3'd3, 1'b0}, 1'b0, 256'h0},
		'{'{32'h0f0f0f0f, 3'd0, 1'b0}, 1'b0, 256'h0},
		'{'{32'h12345678, 3'd1, 1'b1}, 1'b0, 256'h0},
		'{'{32'h9abcdef0, 3'd2, 1'b1}, 1'b0, 256'h0},
		// empty message with junk in the data word
		'{'{32'hffffffff, 3'd0, 1'b1}, 1'b1, EMPTY_DIGEST},
		// count of seven on a last item
		'{'{32'hfedcba98, 3'd7, 1'b1}, 1'b0, 256'h0},
		// "abc" one byte per item: bytes must close up with no holes
		'{'{32'h61ffffff, 3'd1, 1'b0}, 1'b0, 256'h0},
		'{'{32'h62000000, 3'd1, 1'b0}, 1'b0, 256'h0},
		'{'{32'h63aaaaaa, 3'd1, 1'b1}, 1'b1, ABC_DIGEST}
	};

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// Running hash state of the software model of the block
	logic [31:0] chain_h [8];
	logic [7:0]  blk_bytes [64];
	logic [5:0]  fill_pos;
	logic [63:0] bit_total;

	out_item_t digest_q [$];
	out_item_t want_word;
	int        err_count = 0;
	int        burst_left = 0;

	sha256_hash_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #1 clk = ~clk;

	// Hard stop, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Fold the 64 buffered bytes into the chaining value
	task automatic compress_blk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		{a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
			chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
		chain_h[5] += f;
		chain_h[6] += g;
		chain_h[7] += h;
	endtask

	task automatic put_byte(logic [7:0] v);
		blk_bytes[fill_pos] = v;
		fill_pos++;
		if (fill_pos == 6'd0)
			compress_blk();
	endtask

	task automatic restart_hash();
		foreach (chain_h[i])
			chain_h[i] = HASH_INIT[i];
		bit_total = '0;
		fill_pos = '0;
	endtask

	// Take one accepted item; on a last item hand back the finished digest
	task automatic hash_item(in_item_t it, output bit closed, output logic [255:0] dig);
		int          nbytes;
		logic [63:0] len;
		nbytes = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
		for (int i = 0; i < nbytes; i++) begin
			put_byte(it.data_word[31-8*i -: 8]);
			bit_total += 64'd8;
		end
		closed = it.last;
		dig = '0;
		if (it.last) begin
			len = bit_total;
			put_byte(PAD_MARK);
			while (fill_pos != LEN_AT)
				put_byte(8'h00);
			for (int i = 0; i < 8; i++)
				put_byte(len[63-8*i -: 8]);
			dig = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
				chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
			restart_hash();
		end
	endtask

	// Queue the eight words of a digest, most significant first
	task automatic post_digest(logic [255:0] dig);
		out_item_t w;
		for (int i = 0; i < 8; i++) begin
			w.digest_word = dig[255-32*i -: 32];
			w.word_index = 3'(i);
			w.last_word = (i == 7);
			digest_q = {digest_q, w};
		end
	endtask

	// Offer one item, hold it until taken, then predict; a gap follows when a
	// burst runs out
	task automatic send_item(in_item_t it, bit known, logic [255:0] want);
		bit          closed;
		logic [255:0] dig;
		int          gap;
		in_item <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		hash_item(it, closed, dig);
		if (closed)
			post_digest(known ? want : dig);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
				: $urandom_range(1, 8);
		end
	endtask

	// Receiver: keep changing stall behaviour at random, with free-running
	// stretches among them
	initial begin : rx_stall
		rx_mode_t mode;
		int       span;
		wait (arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(8, 120);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_FREE:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
					default:   out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Check every digest word taken against the oldest one waiting
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$error("digest_word: none expected, actual %h", out_item.digest_word);
				err_count++;
			end else begin
				want_word = digest_q.pop_front();
				if (out_item.digest_word !== want_word.digest_word) begin
					$error("digest_word: expected %h, actual %h",
						want_word.digest_word, out_item.digest_word);
					err_count++;
				end
				if (out_item.word_index !== want_word.word_index) begin
					$error("word_index: expected %0d, actual %0d",
						want_word.word_index, out_item.word_index);
					err_count++;
				end
				if (out_item.last_word !== want_word.last_word) begin
					$error("last_word: expected %0d, actual %0d",
						want_word.last_word, out_item.last_word);
					err_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int       taken;
		int       nwords;
		int       pick;
		in_item_t it;
		restart_hash();
		foreach (blk_bytes[i])
			blk_bytes[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table
		for (int r = 0; r < DIR_ROWS; r++)
			send_item(DIR_TABLE[r].item, DIR_TABLE[r].known, DIR_TABLE[r].want);

		// Random messages; lengths cluster round the one- and two-block padding
		// edges, where the length field spills into an extra block
		taken = 0;
		while (taken < RAND_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				nwords = 0;
			else if (pick <= 4)
				nwords = $urandom_range(1, 12);
			else if (pick <= 7)
				nwords = $urandom_range(12, 18);
			else if (pick == 8)
				nwords = $urandom_range(28, 34);
			else
				nwords = $urandom_range(1, 48);
			for (int i = 0; i < nwords; i++) begin
				it.data_word = $urandom;
				it.byte_count = ($urandom_range(0, 9) < 8) ? 3'd4 : 3'($urandom_range(0, 7));
				it.last = 1'b0;
				send_item(it, 1'b0, '0);
				if (it.byte_count != 3'd0)
					taken++;
			end
			it.data_word = $urandom;
			it.byte_count = 3'($urandom_range(0, 7));
			it.last = 1'b1;
			send_item(it, 1'b0, '0);
			taken++;
		end
		in_valid <= 1'b0;

		// Drain, then allow for any stray output
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (err_count == 0 && digest_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sha256_hash_unit.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_dp.sv
rtl/core/sha256_ctrl.sv
rtl/core/sha256_hash_unit.sv
dv/sha256_hash_unit_tb.sv
